// ===== sv/ppmsd_pkg.sv =====
// Shared constants for the point-to-polyline squared distance block.
// Holds the result width, the saturation mask and the configuration register indexes.
// No dependencies; every other file but ppmsd_vtx_if and ppmsd_sqdiv imports this package.
package ppmsd_pkg;

	// Width of the squared distance result, unsigned Q18.24.
	localparam int OUT_BITS = 42;

	// All ones marks "no distance" and is also the saturation value.
	localparam logic [OUT_BITS-1:0] OUT_MASK = '1;

	// Configuration register indexes.
	localparam int CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_POINT_X = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_POINT_Y = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_POINT_Z = 2'd2;

endpackage

// ===== sv/ppmsd_vtx_if.sv =====
// Valid/ready channel that carries one polyline vertex per beat.
// Standalone interface; coordinate width follows COORD_BITS.
interface ppmsd_vtx_if #(
	parameter int COORD_BITS = 20
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] vertex_x;
	logic signed [COORD_BITS-1:0] vertex_y;
	logic signed [COORD_BITS-1:0] vertex_z;
	logic                         is_last;

	modport source (output valid, output vertex_x, output vertex_y, output vertex_z,
		output is_last, input ready);
	modport sink (input valid, input vertex_x, input vertex_y, input vertex_z,
		input is_last, output ready);
endinterface

// ===== sv/ppmsd_res_if.sv =====
// Valid/ready channel that carries one polyline distance result per beat.
// Depends on ppmsd_pkg for the result width.
interface ppmsd_res_if
	import ppmsd_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [OUT_BITS-1:0] min_distance_sq;
	logic                no_segment;

	modport source (output valid, output min_distance_sq, output no_segment, input ready);
	modport sink (input valid, input min_distance_sq, input no_segment, output ready);
endinterface

// ===== sv/point_polyline_min_sq_distance.sv =====
// Point to 3D polyline minimum squared distance, top level.
// Depends on ppmsd_pkg, ppmsd_vtx_if, ppmsd_res_if and ppmsd_sqdiv.
//
// Vertices of a polyline arrive one beat at a time on the vertex channel as
// signed Q8.12 coordinates, and the query point is set through the three
// configuration registers point_x, point_y and point_z (indexes 0 to 2; other
// indexes are ignored). Each vertex after the first closes a segment with the
// vertex before it, and the block folds that segment's squared distance into a
// running minimum. The beat marked is_last produces one result beat: the
// minimum in unsigned Q18.24, or all ones with no_segment set when the polyline
// had a single vertex; the next vertex then starts a new polyline. The block
// takes one vertex at a time. A vertex that closes a segment runs twelve
// products through one shared multiplier, then a region select, the serial
// quotient unit when the projection falls inside the segment, and the update
// of the running minimum; a vertex that carries is_last then loads the output
// register. A finished result is held in that output register, so a new vertex
// is taken while the result waits; a later result waits until that register
// has been emptied.
module point_polyline_min_sq_distance
	import ppmsd_pkg::*;
#(
	parameter int COORD_BITS = 20
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [COORD_BITS-1:0]         cfg_data,
	ppmsd_vtx_if.sink                     vertex,
	ppmsd_res_if.source                   result
);

	// Difference width, product width and the width used for the saturation compare.
	localparam int DW = COORD_BITS + 1;
	localparam int W  = 2 * DW;
	localparam int EW = (W > OUT_BITS) ? W : OUT_BITS;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_SEL  = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_UPD  = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	localparam logic [3:0] MUL_STEPS = 4'd12;

	localparam logic [1:0] ACC_PA2 = 2'd0;
	localparam logic [1:0] ACC_BA2 = 2'd1;
	localparam logic [1:0] ACC_DOT = 2'd2;
	localparam logic [1:0] ACC_PB2 = 2'd3;

	logic [2:0]                  state_q;
	logic [3:0]                  cnt_q;
	logic                        have_prev_q;
	logic                        seg_seen_q;
	logic                        last_q;
	logic [OUT_BITS-1:0]         run_min_q;
	logic                        res_valid_q;
	logic                        vld_s1;

	logic signed [COORD_BITS-1:0] px_q, py_q, pz_q;
	logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q, prev_z_q;
	logic signed [DW-1:0]        pax_q, pay_q, paz_q;
	logic signed [DW-1:0]        bax_q, bay_q, baz_q;
	logic signed [DW-1:0]        pbx_q, pby_q, pbz_q;
	logic signed [W-1:0]         prod_s1;
	logic [1:0]                  grp_s1;
	logic signed [W:0]           pa2_q, ba2_q, dot_q, pb2_q;
	logic [W-1:0]                dist_q;
	logic [OUT_BITS-1:0]         res_dist_q;
	logic                        res_noseg_q;

	logic                        accept;
	logic                        out_free;
	logic signed [DW-1:0]        op_a, op_b;
	logic [1:0]                  grp;
	logic signed [W:0]           prod_ext;
	logic                        dot_le_zero;
	logic                        dot_ge_ba2;
	logic                        div_start;
	logic                        div_done;
	logic [W-1:0]                div_quot;
	logic [EW-1:0]               dist_ext;
	logic [OUT_BITS-1:0]         dist_sat;
	logic [OUT_BITS-1:0]         min_next;

	assign accept   = vertex.valid && vertex.ready;
	assign out_free = !res_valid_q || result.ready;

	assign vertex.ready           = (state_q == S_IDLE);
	assign result.valid           = res_valid_q;
	assign result.min_distance_sq = res_dist_q;
	assign result.no_segment      = res_noseg_q;

	// Operand selection for the shared multiplier: three squares of p-a, three
	// squares of b-a, the three terms of the dot product, then three squares of
	// p-b. The group tells which accumulator the product lands in.
	always_comb begin
		unique case (cnt_q)
			4'd0: begin op_a = pax_q; op_b = pax_q; grp = ACC_PA2; end
			4'd1: begin op_a = pay_q; op_b = pay_q; grp = ACC_PA2; end
			4'd2: begin op_a = paz_q; op_b = paz_q; grp = ACC_PA2; end
			4'd3: begin op_a = bax_q; op_b = bax_q; grp = ACC_BA2; end
			4'd4: begin op_a = bay_q; op_b = bay_q; grp = ACC_BA2; end
			4'd5: begin op_a = baz_q; op_b = baz_q; grp = ACC_BA2; end
			4'd6: begin op_a = pax_q; op_b = bax_q; grp = ACC_DOT; end
			4'd7: begin op_a = pay_q; op_b = bay_q; grp = ACC_DOT; end
			4'd8: begin op_a = paz_q; op_b = baz_q; grp = ACC_DOT; end
			4'd9: begin op_a = pbx_q; op_b = pbx_q; grp = ACC_PB2; end
			4'd10: begin op_a = pby_q; op_b = pby_q; grp = ACC_PB2; end
			4'd11: begin op_a = pbz_q; op_b = pbz_q; grp = ACC_PB2; end
			default: begin op_a = pax_q; op_b = pax_q; grp = ACC_PA2; end
		endcase
	end

	assign prod_ext = {prod_s1[W-1], prod_s1};

	// Region test along the segment. A zero-length segment has a zero dot
	// product and so takes the distance to its start vertex.
	assign dot_le_zero = dot_q[W] || (dot_q == '0);
	assign dot_ge_ba2  = (dot_q[W-1:0] >= ba2_q[W-1:0]);
	assign div_start   = (state_q == S_SEL) && !dot_le_zero && !dot_ge_ba2;

	// Distances above the result range saturate to all ones; this can only
	// happen for coordinate widths above 20 bits.
	always_comb begin
		dist_ext = EW'(dist_q);
		dist_sat = (dist_ext > EW'(OUT_MASK)) ? OUT_MASK : OUT_BITS'(dist_ext);
		min_next = (dist_sat < run_min_q) ? dist_sat : run_min_q;
	end

	ppmsd_sqdiv #(
		.W(W)
	) u_sqdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dot_q[W-1:0]),
		.divisor  (ba2_q[W-1:0]),
		.done     (div_done),
		.quot     (div_quot)
	);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			have_prev_q <= 1'b0;
			seg_seen_q  <= 1'b0;
			last_q      <= 1'b0;
			run_min_q   <= OUT_MASK;
			res_valid_q <= 1'b0;
			vld_s1      <= 1'b0;
			px_q        <= '0;
			py_q        <= '0;
			pz_q        <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_POINT_X: px_q <= cfg_data;
					CFG_POINT_Y: py_q <= cfg_data;
					CFG_POINT_Z: pz_q <= cfg_data;
					default: ;
				endcase
			end

			// A new result beat takes the output register as the old one leaves.
			if (state_q == S_OUT && out_free) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end

			vld_s1 <= (state_q == S_MUL) && (cnt_q < MUL_STEPS);

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						last_q      <= vertex.is_last;
						have_prev_q <= 1'b1;
						cnt_q       <= '0;
						if (have_prev_q) begin
							state_q <= S_MUL;
						end else if (vertex.is_last) begin
							state_q <= S_OUT;
						end
					end
				end
				S_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == MUL_STEPS) begin
						state_q <= S_SEL;
					end
				end
				S_SEL: begin
					state_q <= div_start ? S_DIV : S_UPD;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					run_min_q  <= min_next;
					seg_seen_q <= 1'b1;
					state_q    <= last_q ? S_OUT : S_IDLE;
				end
				S_OUT: begin
					if (out_free) begin
						run_min_q   <= OUT_MASK;
						seg_seen_q  <= 1'b0;
						have_prev_q <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			prev_x_q <= vertex.vertex_x;
			prev_y_q <= vertex.vertex_y;
			prev_z_q <= vertex.vertex_z;
			pax_q <= {px_q[COORD_BITS-1], px_q} - {prev_x_q[COORD_BITS-1], prev_x_q};
			pay_q <= {py_q[COORD_BITS-1], py_q} - {prev_y_q[COORD_BITS-1], prev_y_q};
			paz_q <= {pz_q[COORD_BITS-1], pz_q} - {prev_z_q[COORD_BITS-1], prev_z_q};
			bax_q <= {vertex.vertex_x[COORD_BITS-1], vertex.vertex_x}
				- {prev_x_q[COORD_BITS-1], prev_x_q};
			bay_q <= {vertex.vertex_y[COORD_BITS-1], vertex.vertex_y}
				- {prev_y_q[COORD_BITS-1], prev_y_q};
			baz_q <= {vertex.vertex_z[COORD_BITS-1], vertex.vertex_z}
				- {prev_z_q[COORD_BITS-1], prev_z_q};
			pbx_q <= {px_q[COORD_BITS-1], px_q}
				- {vertex.vertex_x[COORD_BITS-1], vertex.vertex_x};
			pby_q <= {py_q[COORD_BITS-1], py_q}
				- {vertex.vertex_y[COORD_BITS-1], vertex.vertex_y};
			pbz_q <= {pz_q[COORD_BITS-1], pz_q}
				- {vertex.vertex_z[COORD_BITS-1], vertex.vertex_z};
			pa2_q <= '0;
			ba2_q <= '0;
			dot_q <= '0;
			pb2_q <= '0;
		end else if (vld_s1) begin
			unique case (grp_s1)
				ACC_PA2: pa2_q <= pa2_q + prod_ext;
				ACC_BA2: ba2_q <= ba2_q + prod_ext;
				ACC_DOT: dot_q <= dot_q + prod_ext;
				ACC_PB2: pb2_q <= pb2_q + prod_ext;
				default: ;
			endcase
		end

		prod_s1 <= op_a * op_b;
		grp_s1  <= grp;

		if (state_q == S_SEL) begin
			dist_q <= dot_le_zero ? pa2_q[W-1:0] : pb2_q[W-1:0];
		end else if (state_q == S_DIV && div_done) begin
			dist_q <= pa2_q[W-1:0] - div_quot;
		end

		if (state_q == S_OUT && out_free) begin
			res_dist_q  <= seg_seen_q ? run_min_q : OUT_MASK;
			res_noseg_q <= !seg_seen_q;
		end
	end

endmodule

// ===== sv/ppmsd_sqdiv.sv =====
// Serial unit for floor(d*d/b) with 0 < d < b, one bit of d per cycle.
// Self-contained; instantiated by point_polyline_min_sq_distance.
module ppmsd_sqdiv #(
	parameter int W = 42
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quot
);

	localparam int CW = $clog2(W);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  d_q;
	logic [W-1:0]  d_sh_q;
	logic [W-1:0]  b_q;
	logic [W-1:0]  r_q;
	logic [W-1:0]  q_q;

	logic [W+1:0]  t;
	logic [W+1:0]  b1;
	logic [W+1:0]  b2;
	logic [W+1:0]  r_next;
	logic [1:0]    q_inc;
	logic [W-1:0]  q_next;

	// The partial remainder stays below b, so 2r + d stays below 3b and at most
	// two subtractions of b are needed per bit.
	always_comb begin
		t  = {1'b0, r_q, 1'b0} + (d_sh_q[W-1] ? {2'b00, d_q} : '0);
		b1 = {2'b00, b_q};
		b2 = {1'b0, b_q, 1'b0};
		priority if (t >= b2) begin
			r_next = t - b2;
			q_inc  = 2'd2;
		end else if (t >= b1) begin
			r_next = t - b1;
			q_inc  = 2'd1;
		end else begin
			r_next = t;
			q_inc  = 2'd0;
		end
		q_next = {q_q[W-2:0], 1'b0} + W'(q_inc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			d_q    <= dividend;
			d_sh_q <= dividend;
			b_q    <= divisor;
			r_q    <= '0;
			q_q    <= '0;
		end else if (busy_q) begin
			d_sh_q <= {d_sh_q[W-2:0], 1'b0};
			r_q    <= r_next[W-1:0];
			q_q    <= q_next;
		end
	end

	assign done = done_q;
	assign quot = q_q;

endmodule

// ===== tb/ppmsd_distance_checker.sv =====
`timescale 1ns / 1ps
// Checker for the point-to-polyline distance block. It follows the vertex, result and
// configuration traffic, predicts each result and compares it.
// Depends on ppmsd_pkg, ppmsd_vtx_if and ppmsd_res_if.
module ppmsd_distance_checker
	import ppmsd_pkg::*;
#(
	parameter int COORD_BITS = 20
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [COORD_BITS-1:0]   cfg_data,
	ppmsd_vtx_if                    vertex,
	ppmsd_res_if                    result,
	output int                      mismatches,
	output int                      awaited
);

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		logic [OUT_BITS-1:0] min_dist;
		logic                no_seg;
	} polyline_result_t;

	coord_t              qp_x, qp_y, qp_z;
	coord_t              last_x, last_y, last_z;
	logic                have_last;
	logic                any_segment;
	logic [OUT_BITS-1:0] shortest;
	logic [OUT_BITS-1:0] seg_d;
	polyline_result_t    want_beat;
	polyline_result_t    polyline_results_q[$];

	// Exact squared distance from the query point to segment a-b, saturated to the
	// result width.
	function automatic logic [OUT_BITS-1:0] segment_dist_sq(input coord_t ax, ay, az,
			input coord_t bx, by, bz);
		longint       pa_x, pa_y, pa_z, ba_x, ba_y, ba_z, pb_x, pb_y, pb_z, dot;
		logic [63:0]  pa2, ba2, seg_sq;
		logic [127:0] dot_sq;
		pa_x = longint'(qp_x) - longint'(ax);
		pa_y = longint'(qp_y) - longint'(ay);
		pa_z = longint'(qp_z) - longint'(az);
		ba_x = longint'(bx) - longint'(ax);
		ba_y = longint'(by) - longint'(ay);
		ba_z = longint'(bz) - longint'(az);
		pb_x = longint'(qp_x) - longint'(bx);
		pb_y = longint'(qp_y) - longint'(by);
		pb_z = longint'(qp_z) - longint'(bz);
		pa2 = pa_x * pa_x + pa_y * pa_y + pa_z * pa_z;
		ba2 = ba_x * ba_x + ba_y * ba_y + ba_z * ba_z;
		dot = pa_x * ba_x + pa_y * ba_y + pa_z * ba_z;
		if (dot <= 0) begin
			seg_sq = pa2;
		end else if (64'(dot) >= ba2) begin
			seg_sq = pb_x * pb_x + pb_y * pb_y + pb_z * pb_z;
		end else begin
			dot_sq = 128'(dot) * 128'(dot);
			seg_sq = pa2 - 64'(dot_sq / 128'(ba2));
		end
		return (seg_sq > 64'(OUT_MASK)) ? OUT_MASK : seg_sq[OUT_BITS-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qp_x = '0;
			qp_y = '0;
			qp_z = '0;
			last_x = '0;
			last_y = '0;
			last_z = '0;
			have_last = 1'b0;
			any_segment = 1'b0;
			shortest = OUT_MASK;
			polyline_results_q.delete();
			mismatches = 0;
			awaited = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_POINT_X: qp_x = cfg_data;
					CFG_POINT_Y: qp_y = cfg_data;
					CFG_POINT_Z: qp_z = cfg_data;
					default: ;
				endcase
			end

			if (vertex.valid && vertex.ready) begin
				if (have_last) begin
					seg_d = segment_dist_sq(last_x, last_y, last_z,
						vertex.vertex_x, vertex.vertex_y, vertex.vertex_z);
					if (seg_d < shortest)
						shortest = seg_d;
					any_segment = 1'b1;
				end
				last_x = vertex.vertex_x;
				last_y = vertex.vertex_y;
				last_z = vertex.vertex_z;
				have_last = 1'b1;
				if (vertex.is_last) begin
					want_beat.min_dist = any_segment ? shortest : OUT_MASK;
					want_beat.no_seg = !any_segment;
					polyline_results_q.push_back(want_beat);
					have_last = 1'b0;
					any_segment = 1'b0;
					shortest = OUT_MASK;
				end
			end

			if (result.valid && result.ready) begin
				if (polyline_results_q.size() == 0) begin
					$display("%0t: unexpected result beat, min_distance_sq %0d no_segment %0b",
						$time, result.min_distance_sq, result.no_segment);
					mismatches++;
				end else begin
					want_beat = polyline_results_q.pop_front();
					if (result.min_distance_sq !== want_beat.min_dist) begin
						$display("%0t: min_distance_sq mismatch, expected %0d, actual %0d",
							$time, want_beat.min_dist, result.min_distance_sq);
						mismatches++;
					end
					if (result.no_segment !== want_beat.no_seg) begin
						$display("%0t: no_segment mismatch, expected %0b, actual %0b",
							$time, want_beat.no_seg, result.no_segment);
						mismatches++;
					end
				end
			end

			awaited = polyline_results_q.size();
		end
	end

endmodule

// ===== tb/point_polyline_min_sq_distance_tb.sv =====
`timescale 1ns / 1ps
// Top of the testbench for point_polyline_min_sq_distance: clock, reset, vertex and
// configuration stimulus, result back-pressure and the final verdict.
// Depends on ppmsd_pkg, both channel interfaces, the block and ppmsd_distance_checker.
module point_polyline_min_sq_distance_tb
	import ppmsd_pkg::*;
();

	localparam int COORD_BITS = 20;
	// Number of vertex beats in the random part of the run.
	localparam int RANDOM_VERTICES = 1800;
	// A segment whose projection falls inside it takes the longest; this many idle
	// cycles let any trailing work finish before a register write or the verdict.
	localparam int SETTLE_CYCLES = 2 * COORD_BITS + 24;
	// The slowest correct run is roughly 1850 vertices with gaps on both sides, so
	// this limit leaves a wide margin.
	localparam int CYCLE_LIMIT = 1_000_000;
	// Index 3 is not a register; writes there must have no effect.
	localparam logic [CFG_IDX_BITS-1:0] CFG_UNMAPPED = 2'd3;
	localparam logic [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
	localparam logic [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [COORD_BITS-1:0]   cfg_data;

	// When clear, both sides run without gaps, so bursts at full rate are mixed
	// in with the gapped stretches.
	logic idling;

	int mismatches;
	int awaited;
	int vertices_sent;
	int cycle_count;

	// The query point currently programmed; random vertices are placed around it
	// so that all three segment cases come up often.
	logic [COORD_BITS-1:0] aim_x, aim_y, aim_z;

	ppmsd_vtx_if #(.COORD_BITS(COORD_BITS)) vtx_ch ();
	ppmsd_res_if res_ch ();

	point_polyline_min_sq_distance #(.COORD_BITS(COORD_BITS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.vertex    (vtx_ch),
		.result    (res_ch)
	);

	ppmsd_distance_checker #(.COORD_BITS(COORD_BITS)) scoreboard (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.vertex     (vtx_ch),
		.result     (res_ch),
		.mismatches (mismatches),
		.awaited    (awaited)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	// Result side. Each result beat draws its own stall; a nonzero stall holds
	// ready low until valid shows up and then for that many more cycles, so the
	// block has to hold its output register while a new polyline streams in.
	initial begin
		int unsigned stall;
		res_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = idling ? $urandom_range(0, 4) : 0;
			if (stall == 0) begin
				res_ch.ready <= 1'b1;
			end else begin
				res_ch.ready <= 1'b0;
				while (!res_ch.valid) @(negedge clk);
				repeat (stall) @(negedge clk);
				res_ch.ready <= 1'b1;
			end
			@(posedge clk);
			while (!(res_ch.valid && res_ch.ready)) @(posedge clk);
			@(negedge clk);
		end
	end

	// Offers one vertex beat after a random gap and returns at the falling edge
	// that follows its acceptance. Valid stays high between back-to-back beats.
	task automatic send_vertex(input logic [COORD_BITS-1:0] x, y, z, input logic last);
		int unsigned gap;
		gap = idling ? $urandom_range(0, 4) : 0;
		if (gap != 0) begin
			vtx_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		vtx_ch.valid    <= 1'b1;
		vtx_ch.vertex_x <= x;
		vtx_ch.vertex_y <= y;
		vtx_ch.vertex_z <= z;
		vtx_ch.is_last  <= last;
		@(posedge clk);
		while (!vtx_ch.ready) @(posedge clk);
		@(negedge clk);
		vertices_sent++;
	endtask

	// Stops the vertex stream and waits until every predicted result has been
	// taken, then lets the block settle. Register writes only follow this.
	task automatic quiesce();
		vtx_ch.valid <= 1'b0;
		while (awaited != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Drives one register write; the caller lowers the write enable after the last one so
	// that consecutive writes keep it high without a glitch.
	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [COORD_BITS-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
	endtask

	// Programs the query point, then writes random data to the unmapped index,
	// which must leave the point untouched.
	task automatic set_point(input logic [COORD_BITS-1:0] x, y, z);
		aim_x = x;
		aim_y = y;
		aim_z = z;
		write_reg(CFG_POINT_X, x);
		write_reg(CFG_POINT_Y, y);
		write_reg(CFG_POINT_Z, z);
		write_reg(CFG_UNMAPPED, COORD_BITS'($urandom));
		cfg_we <= 1'b0;
	endtask

	function automatic logic [COORD_BITS-1:0] corner();
		return ($urandom_range(0, 1) != 0) ? COORD_MAX : COORD_MIN;
	endfunction

	// A coordinate near the given center, within 2**(spread-1), with the occasional
	// extreme or fully random value mixed in. Wrapping past an extreme is fine:
	// it only produces a long segment.
	function automatic logic [COORD_BITS-1:0] pick_coord(input logic [COORD_BITS-1:0] center,
			input int unsigned spread);
		logic [COORD_BITS-1:0] offset;
		case ($urandom_range(0, 9))
			0: return COORD_MIN;
			1: return COORD_MAX;
			2, 3: return COORD_BITS'($urandom);
			default: begin
				offset = COORD_BITS'($urandom_range(0, (1 << spread) - 1));
				return COORD_BITS'(center + offset - (1 << (spread - 1)));
			end
		endcase
	endfunction

	initial begin
		int unsigned len;
		int unsigned spread;
		int unsigned polylines;
		int          first_random;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		vtx_ch.valid = 1'b0;
		vtx_ch.vertex_x = '0;
		vtx_ch.vertex_y = '0;
		vtx_ch.vertex_z = '0;
		vtx_ch.is_last = 1'b0;
		idling = 1'b0;
		vertices_sent = 0;
		aim_x = '0;
		aim_y = '0;
		aim_z = '0;
		polylines = 0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part, first with the query point still at its reset value,
		// the origin. A lone vertex has no segment and must report all ones.
		send_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
		// The full diagonal passes near the origin: the projection lands inside.
		send_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
		send_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
		// A zero-length segment falls back to the distance to its start.
		send_vertex(20'sd100, -20'sd7, 20'sd3, 1'b0);
		send_vertex(20'sd100, -20'sd7, 20'sd3, 1'b1);
		// Segment pointing away from the point: the start vertex is closest.
		send_vertex(20'sd100, 20'sd0, 20'sd0, 1'b0);
		send_vertex(20'sd200, 20'sd0, 20'sd0, 1'b1);
		// Segment ending short of the point: the end vertex is closest.
		send_vertex(-20'sd200, 20'sd0, 20'sd0, 1'b0);
		send_vertex(-20'sd100, 20'sd0, 20'sd0, 1'b1);

		// Move the point to a corner and run a polyline between opposite corners that
		// ends exactly on the point, then further polylines that start at the origin.
		quiesce();
		set_point(COORD_MAX, COORD_MIN, COORD_MAX);
		send_vertex(COORD_MIN, COORD_MAX, COORD_MIN, 1'b0);
		send_vertex(COORD_MAX, COORD_MIN, COORD_MAX, 1'b1);
		idling = 1'b1;
		send_vertex('0, '0, '0, 1'b0);
		send_vertex(COORD_MIN, COORD_MAX, COORD_MIN, 1'b0);
		send_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
		send_vertex('0, '0, '0, 1'b1);

		// The opposite corner, with the polyline kept far from the point so the
		// distances come close to the top of the result range.
		quiesce();
		set_point(COORD_MIN, COORD_MAX, COORD_MIN);
		send_vertex(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
		send_vertex(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
		send_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
		send_vertex(COORD_MIN, COORD_MIN, COORD_MAX, 1'b1);

		// Random part: polylines of mostly two to eight vertices around the
		// current point at a random scale. The point is reprogrammed now and
		// then, and once in a while the stream pauses until all results are in.
		first_random = vertices_sent;
		while (vertices_sent - first_random < RANDOM_VERTICES) begin
			if (polylines % 64 == 63) begin
				quiesce();
				if ($urandom_range(0, 2) == 0)
					set_point(corner(), corner(), corner());
				else
					set_point(COORD_BITS'($urandom), COORD_BITS'($urandom),
						COORD_BITS'($urandom));
			end else if ($urandom_range(0, 47) == 0) begin
				quiesce();
			end
			idling = ($urandom_range(0, 3) != 0);
			len = ($urandom_range(0, 11) == 0) ? 1 : $urandom_range(2, 8);
			spread = $urandom_range(1, COORD_BITS);
			for (int i = 0; i < len; i++)
				send_vertex(pick_coord(aim_x, spread), pick_coord(aim_y, spread),
					pick_coord(aim_z, spread), i == len - 1);
			polylines++;
		end

		// Drain: every predicted result must arrive, then a few idle cycles
		// catch any stray beat.
		quiesce();
		if (mismatches == 0 && awaited == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
